// File: src/lfr_pkg.sv
// lfr_pkg: shared types, constants and helpers for the lru frame replacer
// no dependencies; imported by lfr_cell, lru_frame_replacer_unit and tb
`default_nettype none

package lfr_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int FRAME_W    = 6;
    localparam int CAP_W      = 7;
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    localparam logic [1:0] OP_VICTIM = 2'd0;
    localparam logic [1:0] OP_PIN    = 2'd1;
    localparam logic [1:0] OP_UNPIN  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [FRAME_W-1:0] frame;
    } lfr_in_t;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] victim_frame;
        logic [CAP_W-1:0]   occupancy;
    } lfr_out_t;

    // one list slot
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } lfr_entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic               insert_go;
        logic [FRAME_W-1:0] key;
    } lfr_bcast_t;

    // log-depth prefix or: bit i is set when any bit at or below i is set
    function automatic logic [NUM_FRAMES-1:0] prefix_or(input logic [NUM_FRAMES-1:0] v);
        logic [NUM_FRAMES-1:0] r;
        r = v;
        for (int s = 1; s < NUM_FRAMES; s = s * 2) begin
            r = r | (r << s);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/lfr_cell.sv
// lfr_cell: one slot of the recency list, shifts toward the lru end on removal
// depends on lfr_pkg
`default_nettype none

module lfr_cell
    import lfr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire lfr_bcast_t bcast,
    input  wire logic       shift,
    input  wire logic       left_valid,
    input  wire lfr_entry_t right_entry,
    output lfr_entry_t      entry,
    output logic            match
);

    logic               valid_reg, valid_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               load;

    // first empty slot takes the inserted frame
    assign load  = bcast.insert_go && !valid_reg && left_valid;
    assign match = valid_reg && (frame_reg == bcast.key);

    always_comb begin
        valid_next = valid_reg;
        frame_next = frame_reg;
        if (shift) begin
            valid_next = right_entry.valid;
            frame_next = right_entry.frame;
        end else if (load) begin
            valid_next = 1'b1;
            frame_next = bcast.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign entry = '{valid: valid_reg, frame: frame_reg};

endmodule

`default_nettype wire

// File: src/lru_frame_replacer_unit.sv
// lru_frame_replacer_unit: top level, row of lfr_cell slots plus presence bits
// depends on lfr_pkg and lfr_cell
//
//  port group  | dir | handshake          | payload
//  s_*         | in  | s_valid / s_ready  | s_payload (lfr_in_t: op, frame)
//  m_*         | out | m_valid / m_ready  | m_payload (lfr_out_t: ok, victim_frame, occupancy)
//  cfg_*       | in  | cfg_wr_en          | cfg_wr_data (capacity)
//
// every request completes in the cycle it is taken; its result is registered and
// shows in the next cycle, so one transaction per cycle while m_ready stays high.
// the longest path is the slot compare, the prefix or over the slot row and the shift.
// s_ready drops only while a result is held and m_ready is low.
// reset empties the list and clears the presence bits at once; capacity returns to 64.
`default_nettype none

module lru_frame_replacer_unit
    import lfr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire lfr_in_t          s_payload,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lfr_out_t              m_payload,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data
);

    logic [CAP_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [NUM_FRAMES-1:0] present_reg, present_next;
    logic                  m_valid_reg;
    lfr_out_t              m_payload_reg, m_payload_next;

    lfr_entry_t            entries [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] match_vec;
    logic [NUM_FRAMES-1:0] remove_vec;
    logic [NUM_FRAMES-1:0] shift_vec;
    lfr_bcast_t            bcast;

    logic accept;
    logic victim_go, pin_hit, unpin_go;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        victim_go = 1'b0;
        pin_hit   = 1'b0;
        unpin_go  = 1'b0;
        if (accept) begin
            unique case (s_payload.op)
                OP_VICTIM: victim_go = (count_reg != '0);
                OP_PIN:    pin_hit   = |match_vec;
                OP_UNPIN:  unpin_go  = !present_reg[s_payload.frame]
                                       && (32'(count_reg) < 32'(cap_reg))
                                       && (32'(count_reg) < NUM_FRAMES);
                default: ;
            endcase
        end
    end

    assign bcast = '{insert_go: unpin_go, key: s_payload.frame};

    // victim removes the head slot, pin removes the matching slot
    always_comb begin
        remove_vec = '0;
        if (victim_go) begin
            remove_vec[0] = 1'b1;
        end else if (pin_hit) begin
            remove_vec = match_vec;
        end
    end

    assign shift_vec = prefix_or(remove_vec);

    for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
        lfr_entry_t right_e;
        logic       left_v;

        if (i == NUM_FRAMES - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_mid
            assign right_e = entries[i+1];
        end

        if (i == 0) begin : g_first
            assign left_v = 1'b1;
        end else begin : g_rest
            assign left_v = entries[i-1].valid;
        end

        lfr_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .bcast       (bcast),
            .shift       (shift_vec[i]),
            .left_valid  (left_v),
            .right_entry (right_e),
            .entry       (entries[i]),
            .match       (match_vec[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        present_next = present_reg;
        if (victim_go) begin
            count_next                        = count_reg - 1'b1;
            present_next[entries[0].frame]    = 1'b0;
        end else if (pin_hit) begin
            count_next                        = count_reg - 1'b1;
            present_next[s_payload.frame]     = 1'b0;
        end else if (unpin_go) begin
            count_next                        = count_reg + 1'b1;
            present_next[s_payload.frame]     = 1'b1;
        end
    end

    always_comb begin
        m_payload_next.ok           = victim_go;
        m_payload_next.victim_frame = victim_go ? entries[0].frame : '0;
        m_payload_next.occupancy    = CAP_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_W'(NUM_FRAMES);
            count_reg   <= '0;
            present_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            present_reg <= present_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

// File: dv/tb.sv
// tb: self-checking testbench for lru_frame_replacer_unit (victim, pin, unpin, capacity)
// depends on lfr_pkg and the lru_frame_replacer_unit rtl; keeps its own lru list to predict results

module tb;
    import lfr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    lfr_in_t          s_payload = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    lfr_out_t         m_payload;
    logic             cfg_wr_en = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;

    lru_frame_replacer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predicted state: front of lru_order is the least recently unpinned frame
    logic [FRAME_W-1:0]    lru_order[$];
    logic [NUM_FRAMES-1:0] in_list = '0;
    logic [CAP_W-1:0]      cap_reg = 7'd64;

    lfr_out_t pending_results[$];
    lfr_out_t want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_evicted = 0;
    int peak_occupancy = 0;
    int stall_cycles = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // work out the result of one request and advance the predicted list
    function automatic lfr_out_t lru_result(input logic [1:0] op, input logic [FRAME_W-1:0] f);
        lfr_out_t r;
        r = '0;
        case (op)
            OP_VICTIM: begin
                if (lru_order.size() > 0) begin
                    r.ok = 1'b1;
                    r.victim_frame = lru_order.pop_front();
                    in_list[r.victim_frame] = 1'b0;
                end
            end
            OP_PIN: begin
                if (in_list[f]) begin
                    foreach (lru_order[i]) begin
                        if (lru_order[i] == f) begin
                            lru_order.delete(i);
                            break;
                        end
                    end
                    in_list[f] = 1'b0;
                end
            end
            OP_UNPIN: begin
                if (!in_list[f] && lru_order.size() < cap_reg && lru_order.size() < NUM_FRAMES) begin
                    lru_order.push_back(f);
                    in_list[f] = 1'b1;
                end
            end
            default: ;
        endcase
        r.occupancy = CAP_W'(lru_order.size());
        return r;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [FRAME_W-1:0] f);
        lfr_out_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= '{op: op, frame: f};
        do @(posedge aclk); while (!s_ready);
        r = lru_result(op, f);
        pending_results.push_back(r);
        n_sent++;
        if (r.ok) n_evicted++;
        if (int'(r.occupancy) > peak_occupancy) peak_occupancy = int'(r.occupancy);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = v;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no request pending");
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (m_payload.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, m_payload.ok);
                    errors++;
                end
                if (m_payload.victim_frame !== want.victim_frame) begin
                    $error("victim_frame: expected %0d, got %0d",
                           want.victim_frame, m_payload.victim_frame);
                    errors++;
                end
                if (m_payload.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, m_payload.occupancy);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // reset capacity of 64 is used here before any write
    task automatic test_directed;
        send_request(OP_VICTIM, 6'd0);
        send_request(OP_PIN, 6'd0);
        send_request(OP_UNUSED, 6'd0);
        send_request(OP_UNPIN, 6'd0);
        send_request(OP_UNPIN, 6'd63);
        send_request(OP_UNPIN, 6'd21);
        send_request(OP_UNPIN, 6'd0);       // already listed, must keep its place
        send_request(OP_UNUSED, 6'd63);
        send_request(OP_PIN, 6'd42);
        send_request(OP_PIN, 6'd63);
        send_request(OP_VICTIM, 6'd63);
        send_request(OP_VICTIM, 6'd0);
        send_request(OP_VICTIM, 6'd0);
    endtask

    task automatic test_capacity_limits;
        set_capacity(7'd0);
        send_request(OP_UNPIN, 6'd5);
        send_request(OP_VICTIM, 6'd0);
        set_capacity(7'd2);
        send_request(OP_UNPIN, 6'd5);
        send_request(OP_UNPIN, 6'd6);
        send_request(OP_UNPIN, 6'd7);
        send_request(OP_PIN, 6'd5);
        send_request(OP_UNPIN, 6'd7);
        send_request(OP_VICTIM, 6'd0);
        // capacity lowered to the current count blocks further inserts
        set_capacity(7'd1);
        send_request(OP_UNPIN, 6'd9);
        set_capacity(7'd127);
        send_request(OP_UNPIN, 6'd1);
    endtask

    task automatic test_random(input int n, input logic [CAP_W-1:0] cap, input int unpin_w,
                               input int s_pct, input int r_pct);
        int roll;
        logic [1:0] op;
        logic [FRAME_W-1:0] f;
        set_capacity(cap);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) drain();
            roll = $urandom_range(99);
            f = FRAME_W'($urandom_range(NUM_FRAMES - 1));
            if (roll < unpin_w) begin
                op = OP_UNPIN;
                // mostly pick an absent frame so the list keeps growing
                if (lru_order.size() < NUM_FRAMES && $urandom_range(99) < 85) begin
                    while (in_list[f]) f = FRAME_W'($urandom_range(NUM_FRAMES - 1));
                end
            end else if (roll < 96) begin
                op = $urandom_range(1) ? OP_PIN : OP_VICTIM;
                if (op == OP_PIN && lru_order.size() > 0 && $urandom_range(99) < 70) begin
                    f = lru_order[$urandom_range(lru_order.size() - 1)];
                end
            end else begin
                op = OP_UNUSED;
            end
            send_request(op, f);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 36;
        recv_idle_pct = 48;
        test_directed();
        test_capacity_limits();
        test_random(150, 7'd127, 85, 36, 48);
        test_random(130, CAP_W'($urandom_range(12, 1)), 45, 48, 36);
        test_random(130, 7'd64, 50, 0, 0);
        drain();
        repeat (5) @(posedge aclk);
        $display("covered %0d requests, %0d results checked, %0d evictions, peak occupancy %0d",
                 n_sent, n_checked, n_evicted, peak_occupancy);
        $display("capacity swept over 0, 1, 2, 64, 127 and a random small value");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
src/lfr_pkg.sv
src/lfr_cell.sv
src/lru_frame_replacer_unit.sv
dv/tb.sv
